[hdl/pid_two_valve_mixer_core_assert.svh]
// assertion macros for the two-valve mixer core
`ifndef PID_TWO_VALVE_MIXER_CORE_ASSERT_SVH
`define PID_TWO_VALVE_MIXER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define PTVM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define PTVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PTVM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PTVM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/ptvm_pkg.sv]
// types and constants for the two-valve mixer core
`default_nettype none

package ptvm_pkg;

   localparam int PWM_MIN_TICKS_DEF = 1000;
   localparam int PWM_MAX_TICKS_DEF = 2000;

   localparam int FULL_OPEN = 25600;
   localparam int HALF_OPEN = 12800;

   // floor division by 25600: shift by 10, then reciprocal of 25
   localparam int DIV_SHIFT   = 10;
   localparam int RECIP_25    = 2684355;
   localparam int RECIP_SHIFT = 26;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_LOW    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_HIGH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VALVE_FLOOR = 3'd7;

   typedef struct packed {
      logic signed [15:0] temp_sample;
      logic               read_failed;
   } req_word_type;

   typedef struct packed {
      logic               sensor_fault;
      logic signed [15:0] drive_level;
      logic [14:0]        cold_open;
      logic [14:0]        hot_open;
      logic [15:0]        cold_compare;
      logic [15:0]        hot_compare;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_CLAMP,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_SPLIT,
      ST_COLD_MUL,
      ST_COLD_RECIP,
      ST_COLD_DONE,
      ST_HOT_RECIP,
      ST_HOT_DONE,
      ST_OUT
   } ptvm_state_type;

endpackage

`default_nettype wire

[hdl/pid_two_valve_mixer_core.sv]
// two-valve mixer pid core with one shared multiplier
//
// usage:
//   req channel (req_valid/req_ready/req_word) takes one temperature word:
//   a signed sample in 1/128 degree and a read-failure flag.
//   rsp channel (rsp_valid/rsp_ready/rsp_word) returns one word per request:
//   fault flag, clamped drive level, cold/hot openings and pwm compares.
//   csr port (csr_wen/csr_index/csr_wdata) writes the eight settings with no
//   wait; write only while no request is in flight. writing the setpoint
//   clears the integral sum and the previous error.
//   a good sample passes through the pid multiply steps; a faulted one skips
//   them. the next request is taken only once the last word has left the
//   last step. all products come from the single 26x24 multiplier
//   that computes the three pid terms and, per valve, the open-to-ticks
//   product and the reciprocal divide by 25600.
//   the result sits in an output register; a stalled receiver holds it
//   there while the core finishes the next word, and that word waits in
//   the last step until the register frees.
//   reset (synchronous, active high) restores the register defaults and
//   clears the integral sum, previous error and the response valid flag.
`default_nettype none

module pid_two_valve_mixer_core
   import ptvm_pkg::*;
#(
   parameter int PWM_MIN_TICKS = PWM_MIN_TICKS_DEF,
   parameter int PWM_MAX_TICKS = PWM_MAX_TICKS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  req_word_type            req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rsp_word_type            rsp_word,
   input  wire                     csr_wen,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]   csr_wdata
);

`include "pid_two_valve_mixer_core_assert.svh"

   localparam int PWM_DIFF = PWM_MAX_TICKS - PWM_MIN_TICKS;

   // settings
   logic signed [15:0] target_temp_ff;
   logic [15:0]        gain_prop_ff;
   logic [15:0]        gain_integ_ff;
   logic [15:0]        gain_deriv_ff;
   logic [22:0]        integ_limit_ff;
   logic signed [15:0] safe_low_ff;
   logic signed [15:0] safe_high_ff;
   logic [14:0]        valve_floor_ff;

   // loop state
   logic signed [24:0] error_sum_ff;
   logic signed [17:0] last_error_ff;

   // work registers
   ptvm_state_type     state_ff, state_in;
   req_word_type       req_ff;
   logic               fault_ff;
   logic signed [16:0] err_ff;
   logic signed [17:0] dterm_ff;
   logic signed [24:0] sum_ff;
   logic signed [34:0] acc_ff;
   logic signed [15:0] drive_ff;
   logic [14:0]        cold_ff;
   logic [14:0]        hot_ff;
   logic               neg_ff;
   logic [15:0]        cold_cmp_ff;
   logic [15:0]        hot_cmp_ff;
   logic signed [49:0] prod_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_ff;

   // shared multiplier
   logic signed [25:0] mul_a;
   logic signed [23:0] mul_b;
   logic signed [49:0] prod_in;

   logic               fault_c;
   logic signed [15:0] sp_bounded_c;
   logic signed [16:0] err_c;
   logic signed [24:0] limit_c;
   logic signed [24:0] sum_clamped_c;
   logic signed [34:0] term_c;
   logic signed [15:0] drive_c;
   logic signed [15:0] half_c;
   logic signed [16:0] cold_raw_c;
   logic signed [16:0] hot_raw_c;
   logic signed [16:0] floor_c;
   logic [14:0]        cold_c;
   logic [14:0]        hot_c;
   logic signed [39:0] scaled_c;
   logic [20:0]        scaled_mag_c;
   logic [16:0]        quot_c;
   logic signed [17:0] quot_signed_c;
   logic [15:0]        cmp_c;
   logic               rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign prod_in = 50'(mul_a) * 50'(mul_b);

   // error and integral
   always_comb begin
      fault_c = req_ff.read_failed ||
                !(req_ff.temp_sample > safe_low_ff && req_ff.temp_sample < safe_high_ff);
      if (target_temp_ff < safe_low_ff) begin
         sp_bounded_c = safe_low_ff;
      end else if (target_temp_ff > safe_high_ff) begin
         sp_bounded_c = safe_high_ff;
      end else begin
         sp_bounded_c = target_temp_ff;
      end
      err_c   = 17'(sp_bounded_c) - 17'(req_ff.temp_sample);
      limit_c = $signed({2'b00, integ_limit_ff});
      if (sum_ff > limit_c) begin
         sum_clamped_c = limit_c;
      end else if (sum_ff < -limit_c) begin
         sum_clamped_c = -limit_c;
      end else begin
         sum_clamped_c = sum_ff;
      end
      term_c = 35'(prod_ff >>> 8);
   end

   // output split and valve openings
   always_comb begin
      if (acc_ff > 35'sd25600) begin
         drive_c = 16'(FULL_OPEN);
      end else if (acc_ff < -35'sd25600) begin
         drive_c = -16'(FULL_OPEN);
      end else begin
         drive_c = 16'(acc_ff);
      end
      half_c     = (drive_c + $signed({15'd0, drive_c[15]})) >>> 1;
      cold_raw_c = 17'(HALF_OPEN) - 17'(half_c);
      hot_raw_c  = 17'(HALF_OPEN) + 17'(half_c);
      floor_c    = $signed({2'b00, valve_floor_ff});
      if (cold_raw_c < floor_c) cold_raw_c = floor_c;
      if (cold_raw_c > 17'sd25600) cold_raw_c = 17'(FULL_OPEN);
      if (hot_raw_c < floor_c) hot_raw_c = floor_c;
      if (hot_raw_c > 17'sd25600) hot_raw_c = 17'(FULL_OPEN);
      cold_c = fault_ff ? 15'(HALF_OPEN) : cold_raw_c[14:0];
      hot_c  = fault_ff ? 15'(HALF_OPEN) : hot_raw_c[14:0];
   end

   // ticks: floor(open * diff / 25600) by shift and reciprocal of 25
   always_comb begin
      scaled_c      = 40'(prod_ff >>> DIV_SHIFT);
      scaled_mag_c  = scaled_c[39] ? ~scaled_c[20:0] : scaled_c[20:0];
      quot_c        = 17'(prod_ff >>> RECIP_SHIFT);
      quot_signed_c = neg_ff ? ~$signed({1'b0, quot_c}) : $signed({1'b0, quot_c});
      cmp_c         = 16'(18'(PWM_MIN_TICKS) + quot_signed_c);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = fault_c ? ST_SPLIT : ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_a    = 26'(err_ff);
            mul_b    = $signed({8'd0, gain_prop_ff});
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            mul_a    = 26'(error_sum_ff);
            mul_b    = $signed({8'd0, gain_integ_ff});
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = 26'(dterm_ff);
            mul_b    = $signed({8'd0, gain_deriv_ff});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            state_in = ST_COLD_MUL;
         end
         ST_COLD_MUL: begin
            mul_a    = $signed({11'd0, cold_ff});
            mul_b    = 24'(PWM_DIFF);
            state_in = ST_COLD_RECIP;
         end
         ST_COLD_RECIP: begin
            mul_a    = $signed({5'd0, scaled_mag_c});
            mul_b    = 24'(RECIP_25);
            state_in = ST_COLD_DONE;
         end
         ST_COLD_DONE: begin
            mul_a    = $signed({11'd0, hot_ff});
            mul_b    = 24'(PWM_DIFF);
            state_in = ST_HOT_RECIP;
         end
         ST_HOT_RECIP: begin
            mul_a    = $signed({5'd0, scaled_mag_c});
            mul_b    = 24'(RECIP_25);
            state_in = ST_HOT_DONE;
         end
         ST_HOT_DONE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // settings and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff <= 16'sd2816;
         gain_prop_ff   <= 16'd256;
         gain_integ_ff  <= '0;
         gain_deriv_ff  <= '0;
         integ_limit_ff <= 23'd1048576;
         safe_low_ff    <= '0;
         safe_high_ff   <= 16'sd6400;
         valve_floor_ff <= '0;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_TARGET_TEMP: begin
               target_temp_ff <= $signed(csr_wdata[15:0]);
               error_sum_ff   <= '0;
               last_error_ff  <= '0;
            end
            CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata[15:0];
            CSR_GAIN_INTEG:  gain_integ_ff  <= csr_wdata[15:0];
            CSR_GAIN_DERIV:  gain_deriv_ff  <= csr_wdata[15:0];
            CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata[22:0];
            CSR_SAFE_LOW:    safe_low_ff    <= $signed(csr_wdata[15:0]);
            CSR_SAFE_HIGH:   safe_high_ff   <= $signed(csr_wdata[15:0]);
            CSR_VALVE_FLOOR: valve_floor_ff <= csr_wdata[14:0];
         endcase
      end else if (state_ff == ST_CLAMP) begin
         error_sum_ff  <= sum_clamped_c;
         last_error_ff <= 18'(err_ff);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) req_ff <= req_word;
         end
         ST_PREP: begin
            fault_ff <= fault_c;
            err_ff   <= err_c;
            dterm_ff <= 18'(err_c) - last_error_ff;
            sum_ff   <= error_sum_ff + 25'(err_c);
            acc_ff   <= '0;
         end
         ST_MUL_I: acc_ff <= term_c;
         ST_MUL_D: acc_ff <= acc_ff + term_c;
         ST_ACC:   acc_ff <= acc_ff + term_c;
         ST_SPLIT: begin
            drive_ff <= fault_ff ? 16'sd0 : drive_c;
            cold_ff  <= cold_c;
            hot_ff   <= hot_c;
         end
         ST_COLD_RECIP, ST_HOT_RECIP: neg_ff <= scaled_c[39];
         ST_COLD_DONE: cold_cmp_ff <= cmp_c;
         ST_HOT_DONE:  hot_cmp_ff  <= cmp_c;
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_ff.sensor_fault <= fault_ff;
         rsp_ff.drive_level  <= drive_ff;
         rsp_ff.cold_open    <= cold_ff;
         rsp_ff.hot_open     <= hot_ff;
         rsp_ff.cold_compare <= cold_cmp_ff;
         rsp_ff.hot_compare  <= hot_cmp_ff;
      end
   end

   `PTVM_ASSERT_IMPLY(a_fault_neutral, clock, reset, rsp_valid_ff && rsp_ff.sensor_fault, rsp_ff.drive_level == 16'sd0 && rsp_ff.cold_open == 15'(HALF_OPEN) && rsp_ff.hot_open == 15'(HALF_OPEN))
   `PTVM_ASSERT_IMPLY(a_open_range, clock, reset, rsp_valid_ff, rsp_ff.cold_open <= 15'(FULL_OPEN) && rsp_ff.hot_open <= 15'(FULL_OPEN))
   `PTVM_ASSERT_NEXT(a_target_clears, clock, reset, csr_wen && csr_index == CSR_TARGET_TEMP, error_sum_ff == 25'sd0 && last_error_ff == 18'sd0)
   `PTVM_ASSERT_IMPLY(a_fault_no_update, clock, reset, state_ff == ST_CLAMP, !fault_ff)

endmodule

`default_nettype wire
